// ===== hdl/lirt_pkg.sv =====
// ----------------------------------------------------------------------------
// lirt_pkg - shared constants and types for the increasing run tracker
// Sizes of the tail store and the counters, and the structs passed between
// the search sequencer and the top level.
// ----------------------------------------------------------------------------
package lirt_pkg;

   localparam int MAX_LENGTH = 256;
   localparam int ADDR_W     = $clog2(MAX_LENGTH);
   localparam int CNT_W      = $clog2(MAX_LENGTH + 1);

   localparam int VALUE_W    = 8;
   localparam int RUN_W      = 9;
   localparam int ELEM_W     = 9;
   localparam int POS_W      = 8;
   localparam int WEIGHT_W   = 8;

   localparam logic [CNT_W-1:0]    LEN_FULL   = CNT_W'(MAX_LENGTH);
   localparam logic [ADDR_W-1:0]   SLOT_LAST  = ADDR_W'(MAX_LENGTH - 1);
   localparam logic [ELEM_W-1:0]   ELEM_MAX   = '1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

   localparam int RSP_FIELDS_W = RUN_W + RUN_W + POS_W + WEIGHT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } lirt_rd_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [ADDR_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
   } lirt_status_type;

endpackage

// ===== hdl/lirt_tail_mem.sv =====
// ----------------------------------------------------------------------------
// lirt_tail_mem - tail value store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lirt_tail_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [lirt_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [lirt_pkg::VALUE_W-1:0]  wr_data,
   input  lirt_pkg::lirt_rd_type         rd,
   output logic [lirt_pkg::VALUE_W-1:0]  rd_data
);

   logic [lirt_pkg::VALUE_W-1:0] mem_ff [lirt_pkg::MAX_LENGTH];
   logic [lirt_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd.rd_en) begin
         rd_data_ff <= mem_ff[rd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lirt_search.sv =====
// ----------------------------------------------------------------------------
// lirt_search - lower-bound search sequencer
// Halves the window [lo, hi) over the tail store one probe at a time, using
// a single compare unit against the registered read data.
// ----------------------------------------------------------------------------
module lirt_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lirt_pkg::VALUE_W-1:0]  start_value,
   input  logic [lirt_pkg::CNT_W-1:0]    start_limit,
   input  logic                          ack,
   input  logic [lirt_pkg::VALUE_W-1:0]  rd_data,
   output lirt_pkg::lirt_rd_type         rd,
   output lirt_pkg::lirt_status_type     status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_COMPARE,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [lirt_pkg::CNT_W-1:0]    lo_ff, lo_in;
   logic [lirt_pkg::CNT_W-1:0]    hi_ff, hi_in;
   logic [lirt_pkg::ADDR_W-1:0]   mid_ff, mid_in;
   logic [lirt_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [lirt_pkg::CNT_W:0]      sum;
   logic [lirt_pkg::ADDR_W-1:0]   mid;

   assign sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid = sum[lirt_pkg::ADDR_W:1];

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      value_in = value_ff;
      rd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               lo_in    = '0;
               hi_in    = start_limit;
               value_in = start_value;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               rd.rd_en   = 1'b1;
               rd.rd_addr = mid;
               mid_in     = mid;
               state_in   = S_COMPARE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_COMPARE: begin
            if (value_ff > rd_data) begin
               lo_in = lirt_pkg::CNT_W'(mid_ff) + lirt_pkg::CNT_W'(1);
            end else begin
               hi_in = lirt_pkg::CNT_W'(mid_ff);
            end
            state_in = S_PROBE;
         end
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      value_ff <= value_in;
   end

   assign status.busy  = (state_ff != S_IDLE);
   assign status.done  = (state_ff == S_DONE);
   assign status.slot  = (lo_ff == lirt_pkg::LEN_FULL) ? lirt_pkg::SLOT_LAST
                                                      : lo_ff[lirt_pkg::ADDR_W-1:0];
   assign status.value = value_ff;

endmodule

// ===== hdl/longest_increasing_run_tracker.sv =====
// ----------------------------------------------------------------------------
// longest_increasing_run_tracker - longest increasing run per element
// Patience-style tracker: each element is placed at the lower-bound slot of
// the smallest-tail store and reports the run length ending there.
//
// Usage:
//   req channel: one beat per element. tdata[7:0] = value,
//   tuser[0] = first (starts a new sequence, clearing counters).
//   rsp channel: one beat per element, fields listed at the port.
//   An element is searched in k probes of the binary search from acceptance
//   to result (k <= 9 for 256 tails); each probe is one registered read of
//   the tail store and one compare. The next element is taken the cycle
//   after the result is loaded.
//   A finished result waits in the output register; a new element is
//   accepted and searched meanwhile, and only its final update waits until
//   the output register is free.
//   Reset clears the counters and the channels; the tail store is not
//   cleared, since only entries written in the current sequence are read.
// ----------------------------------------------------------------------------
module longest_increasing_run_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // value[7:0]
   input  logic [0:0]                         req_tuser,  // first[0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // run_length[8:0], best_length[17:9], best_position[25:18],
   // insertion_weight[33:26], zero[39:34]
   output logic [lirt_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   lirt_pkg::lirt_rd_type              rd;
   lirt_pkg::lirt_status_type          status;
   logic [lirt_pkg::VALUE_W-1:0]       rd_data;
   logic                               req_fire;
   logic                               first;
   logic                               out_free;
   logic                               ack;

   logic [lirt_pkg::CNT_W-1:0]         tails_count_ff, tails_count_in;
   logic [lirt_pkg::ELEM_W-1:0]        elem_count_ff, elem_count_in;
   logic [lirt_pkg::RUN_W-1:0]         best_ff, best_in;
   logic [lirt_pkg::POS_W-1:0]         best_pos_ff, best_pos_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lirt_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [lirt_pkg::RUN_W-1:0]         run;
   logic [lirt_pkg::ELEM_W-1:0]        diff;
   logic [lirt_pkg::WEIGHT_W-1:0]      weight;

   assign req_tready = !status.busy;
   assign req_fire   = req_tvalid && req_tready;
   assign first      = req_tuser[0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ack        = status.done && out_free;

   lirt_tail_mem u_mem (
      .clock   (clock),
      .wr_en   (ack),
      .wr_addr (status.slot),
      .wr_data (status.value),
      .rd      (rd),
      .rd_data (rd_data)
   );

   lirt_search u_search (
      .clock       (clock),
      .reset       (reset),
      .start       (req_fire),
      .start_value (req_tdata),
      .start_limit (first ? '0 : tails_count_ff),
      .ack         (ack),
      .rd_data     (rd_data),
      .rd          (rd),
      .status      (status)
   );

   assign run = lirt_pkg::RUN_W'(status.slot) + lirt_pkg::RUN_W'(1);

   always_comb begin
      tails_count_in = tails_count_ff;
      elem_count_in  = elem_count_ff;
      best_in        = best_ff;
      best_pos_in    = best_pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      diff           = '0;
      weight         = '0;
      if (req_fire && first) begin
         tails_count_in = '0;
         elem_count_in  = '0;
         best_in        = '0;
         best_pos_in    = '0;
      end
      if (ack) begin
         if (lirt_pkg::CNT_W'(status.slot) == tails_count_ff) begin
            tails_count_in = lirt_pkg::CNT_W'(run);
         end
         if (run >= best_ff) begin
            best_in     = run;
            best_pos_in = elem_count_ff[lirt_pkg::POS_W-1:0];
         end
         if (elem_count_ff != lirt_pkg::ELEM_MAX) begin
            elem_count_in = elem_count_ff + lirt_pkg::ELEM_W'(1);
         end
         if (elem_count_in >= best_in) begin
            diff = elem_count_in - best_in;
         end
         weight = (diff > lirt_pkg::ELEM_W'(lirt_pkg::WEIGHT_MAX))
                  ? lirt_pkg::WEIGHT_MAX : diff[lirt_pkg::WEIGHT_W-1:0];
         rsp_valid_in = 1'b1;
         rsp_data_in  = lirt_pkg::RSP_DATA_W'({weight, best_pos_in, best_in, run});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tails_count_ff <= '0;
         elem_count_ff  <= '0;
         best_ff        <= '0;
         best_pos_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tails_count_ff <= tails_count_in;
         elem_count_ff  <= elem_count_in;
         best_ff        <= best_in;
         best_pos_ff    <= best_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/lirt_checker.sv =====
// ----------------------------------------------------------------------------
// lirt_checker - port-level checks for the increasing run tracker
// Watches the request and result channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module lirt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lirt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a search runs");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:0] != 9'd0) && (rsp_tdata[17:9] >= rsp_tdata[8:0]))
      else $error("run length zero or above best length");

endmodule

bind longest_increasing_run_tracker lirt_checker u_lirt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
